[design/lts_pkg.sv]
// Package for the loss-tolerant stop-and-wait sender.
// Holds window sizing, event and action codes, and shared structs; no dependencies.
package lts_pkg;

  localparam int WINDOW     = 10;   // outcome ring depth, 2..64
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int LOSS_SCALE = 100;  // percent scale of the loss test
  localparam int PROD_W     = $clog2(128 * WINDOW);

  localparam int THR_W = 7;
  localparam int MAX_W = 8;
  localparam int LEN_W = 16;
  localparam int LOST_W = 4;

  localparam logic [THR_W-1:0] THR_RESET = 7'd10;
  localparam logic [MAX_W-1:0] MAX_RESET = 8'd100;

  // configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MAX_SENDS = 1'b1;

  typedef enum logic [1:0] {
    EV_SEND    = 2'd0,
    EV_ACK     = 2'd1,
    EV_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_TRANSMIT = 3'd1,
    ACT_ACKED    = 3'd2,
    ACT_LOSS_OK  = 3'd3,
    ACT_LIMIT    = 3'd4,
    ACT_BAD      = 3'd5
  } action_t;

  // ring update request from control to the outcome window
  typedef struct packed {
    logic wr_en;
    logic wr_val;   // 1 success, 0 loss
    logic adv;
  } win_cmd_t;

  typedef struct packed {
    logic [2:0]       action;
    logic             seq_bit;
    logic [LEN_W-1:0] length;
    logic [LOST_W-1:0] lost_count;
  } result_t;

endpackage

[design/lts_window.sv]
// Outcome ring of the sender: one success/loss bit per slot and the slot pointer.
// Counts losses with the current slot taken as lost. Uses lts_pkg.
module lts_window import lts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  win_cmd_t         cmd,
  output logic [CNT_W-1:0] losses
);

  logic [WINDOW-1:0] win_r, win_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [WINDOW-1:0] loss_mask;

  // popcount of lost slots, current slot counted as lost
  always_comb begin
    losses = '0;
    for (int i = 0; i < WINDOW; i++) begin
      loss_mask[i] = ~win_r[i] | (slot_r == SLOT_W'(i));
      losses = losses + CNT_W'(loss_mask[i]);
    end
  end

  always_comb begin
    win_nxt  = win_r;
    slot_nxt = slot_r;
    if (cmd.wr_en) begin
      win_nxt[slot_r] = cmd.wr_val;
    end
    if (cmd.adv) begin
      slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '1;
      slot_r <= '0;
    end else begin
      win_r  <= win_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

[design/lts_ctrl.sv]
// Protocol control of the sender: waiting flag, sequence bit, send counter,
// held length and configuration registers; decides each event's result. Uses lts_pkg.
module lts_ctrl import lts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [MAX_W-1:0] cfg_wdata,
  input  logic             accept,
  input  logic [1:0]       kind,
  input  logic [LEN_W-1:0] msg_len,
  input  logic             ack_flag,
  input  logic             ack_number,
  input  logic [CNT_W-1:0] losses,
  output win_cmd_t         cmd,
  output result_t          res
);

  logic             waiting_r, waiting_nxt;
  logic             next_seq_r, next_seq_nxt;
  logic [MAX_W-1:0] send_cnt_r, send_cnt_nxt;
  logic [LEN_W-1:0] held_len_r, held_len_nxt;
  logic [THR_W-1:0] thr_r;
  logic [MAX_W-1:0] max_sends_r;

  logic [PROD_W-1:0] loss_prod, thr_prod;
  logic              loss_ok;
  logic [7:0]        losses_ext;
  logic [LOST_W-1:0] lost_sat;
  win_cmd_t          cmd_raw;

  assign loss_prod  = PROD_W'(losses) * PROD_W'(LOSS_SCALE);
  assign thr_prod   = PROD_W'(thr_r) * PROD_W'(WINDOW);
  assign loss_ok    = (loss_prod <= thr_prod);
  assign losses_ext = 8'(losses);
  assign lost_sat   = (losses_ext > 8'd15) ? 4'd15 : losses_ext[LOST_W-1:0];

  always_comb begin
    waiting_nxt  = waiting_r;
    next_seq_nxt = next_seq_r;
    send_cnt_nxt = send_cnt_r;
    held_len_nxt = held_len_r;
    cmd_raw      = '0;
    res          = '0;
    res.action   = ACT_BAD;
    priority if (kind == EV_SEND && !waiting_r) begin
      res.action   = ACT_TRANSMIT;
      res.seq_bit  = next_seq_r;
      res.length   = msg_len;
      held_len_nxt = msg_len;
      next_seq_nxt = ~next_seq_r;
      send_cnt_nxt = MAX_W'(1);
      waiting_nxt  = 1'b1;
    end else if (kind == EV_ACK && waiting_r) begin
      if (ack_flag && (ack_number == next_seq_r)) begin
        res.action     = ACT_ACKED;
        cmd_raw.wr_en  = 1'b1;
        cmd_raw.wr_val = 1'b1;
        cmd_raw.adv    = 1'b1;
        waiting_nxt    = 1'b0;
      end else begin
        res.action = ACT_IGNORED;
      end
    end else if (kind == EV_TIMEOUT && waiting_r) begin
      cmd_raw.wr_en  = 1'b1;
      cmd_raw.wr_val = 1'b0;
      res.lost_count = lost_sat;
      if (loss_ok) begin
        res.action   = ACT_LOSS_OK;
        next_seq_nxt = ~next_seq_r;
        cmd_raw.adv  = 1'b1;
        waiting_nxt  = 1'b0;
      end else if (send_cnt_r < max_sends_r) begin
        // retransmit with the bit of the first transmission
        res.action   = ACT_TRANSMIT;
        res.seq_bit  = ~next_seq_r;
        res.length   = held_len_r;
        send_cnt_nxt = send_cnt_r + 1'b1;
      end else begin
        res.action  = ACT_LIMIT;
        waiting_nxt = 1'b0;
      end
    end else begin
      res.action = ACT_BAD;
    end
  end

  assign cmd = accept ? cmd_raw : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      next_seq_r  <= 1'b0;
      send_cnt_r  <= '0;
      held_len_r  <= '0;
      thr_r       <= THR_RESET;
      max_sends_r <= MAX_RESET;
    end else begin
      if (accept) begin
        waiting_r  <= waiting_nxt;
        next_seq_r <= next_seq_nxt;
        send_cnt_r <= send_cnt_nxt;
        held_len_r <= held_len_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
          REG_MAX_SENDS: max_sends_r <= cfg_wdata;
          default:       ;
        endcase
      end
    end
  end

endmodule

[design/loss_tolerant_stop_and_wait_sender.sv]
// Stop-and-wait sender, alternating sequence bit, loss-tolerant retransmit policy.
// The result of an accepted input beat is registered and appears on out_* in the next cycle.
// Throughput: 1 beat per cycle; the output register accepts a new beat while its
// current one is being taken, so in_tready drops only when a result sits unread.
// Reset (rst_n low, synchronous): idle, sequence bit 0, ring all successes, slot 0,
// threshold 10 percent, max_sends 100, result register empty.
module loss_tolerant_stop_and_wait_sender import lts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] msg_len, [16] ack_flag, [17] ack_number, zero pad
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] seq_bit, [16:1] length, [20:17] lost_count, zero pad
  output logic [2:0]  out_tuser   // [2:0] action
);

  logic     accept;
  logic [CNT_W-1:0] losses;
  win_cmd_t cmd;
  result_t  res;

  logic     out_valid_r;
  result_t  out_res_r;

  // output register doubles as the skid stage: free when empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  lts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .kind       (in_tuser),
    .msg_len    (in_tdata[15:0]),
    .ack_flag   (in_tdata[16]),
    .ack_number (in_tdata[17]),
    .losses     (losses),
    .cmd        (cmd),
    .res        (res)
  );

  lts_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .losses (losses)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {3'b000, out_res_r.lost_count, out_res_r.length, out_res_r.seq_bit};

endmodule

[design/lts_checker.sv]
// Port-level checker for the stop-and-wait sender, bound to the top level.
// Uses lts_pkg action and event codes.
module lts_checker import lts_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // every accepted event yields a result beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted event produced no result");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // undefined event code is always rejected
  a_bad_kind: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == 2'd3 |=> out_tuser == ACT_BAD)
    else $error("undefined event not reported as bad");

  // sequence bit and length only on transmit beats
  a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_TRANSMIT |-> out_tdata[16:0] == 17'd0)
    else $error("sequence or length set on a non-transmit result");

endmodule

bind loss_tolerant_stop_and_wait_sender lts_checker u_lts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
